### src/clock_display_digit_formatter_macros.svh
// Assertion macros shared by the checker of the clock display formatter.
`ifndef CLOCK_DISPLAY_DIGIT_FORMATTER_MACROS_SVH
`define CLOCK_DISPLAY_DIGIT_FORMATTER_MACROS_SVH

// Check cons in the same cycle as ante.
`define CDF_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("clock display formatter check failed");

// Check cons in the cycle after ante.
`define CDF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("clock display formatter check failed");

`endif

### src/cdf_pkg.sv
// Types, codes and digit helpers for the clock display formatter.
`default_nettype none

package cdf_pkg;

  localparam int IN_BYTES  = 5;
  localparam int OUT_BYTES = 7;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 6;

  localparam logic [CFG_IDX_W-1:0] REG_TWELVE_HOUR  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LEADING_ZERO = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DATE_ORDER   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ALT_PERIOD   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ALT_INVERT   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TIME_MODE    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_INDICATOR    = 3'd6;

  localparam logic       RST_TWELVE_HOUR  = 1'b0;
  localparam logic       RST_LEADING_ZERO = 1'b1;
  localparam logic [1:0] RST_DATE_ORDER   = 2'd0;
  localparam logic [5:0] RST_ALT_PERIOD   = 6'd0;
  localparam logic       RST_ALT_INVERT   = 1'b0;
  localparam logic       RST_TIME_MODE    = 1'b1;
  localparam logic [2:0] RST_INDICATOR    = 3'd0;

  localparam logic [1:0] DATE_DMY = 2'd0;
  localparam logic [1:0] DATE_MDY = 2'd1;

  localparam logic [2:0] IND_ALWAYS = 3'd1;
  localparam logic [2:0] IND_BLINK  = 3'd2;
  localparam logic [2:0] IND_PM     = 3'd3;
  localparam logic [2:0] IND_ALT_A  = 3'd4;
  localparam logic [2:0] IND_ALT_B  = 3'd5;

  localparam logic [2:0] COLON_OFF = 3'd0;
  localparam logic [2:0] COLON_ON  = 3'd1;
  localparam logic [2:0] COLON_C2  = 3'd2;
  localparam logic [2:0] COLON_C3  = 3'd3;
  localparam logic [2:0] COLON_C4  = 3'd4;
  localparam logic [2:0] COLON_C5  = 3'd5;

  localparam logic [3:0] BLANK_NIBBLE = 4'hC;
  localparam logic [7:0] TOP_BYTE     = 8'hCC;
  localparam logic [5:0] WIN_FIRST    = 6'd45;
  localparam logic [5:0] WIN_LAST     = 6'd52;
  localparam logic [4:0] NOON         = 5'd12;

  typedef struct packed {
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [6:0]  year;
    logic        pm;
    logic [4:0]  hour_disp;
    logic [5:0]  rem;
    logic [16:0] hour_sec;
    logic [11:0] min_sec;
  } s1_t;

  typedef struct packed {
    logic        show_time;
    logic        odd;
    logic        pm;
    logic [7:0]  hour_byte;
    logic [7:0]  min_byte;
    logic [7:0]  sec_byte;
    logic [7:0]  day_byte;
    logic [7:0]  month_byte;
    logic [7:0]  year_byte;
    logic [16:0] sod;
  } s2_t;

  // Units digit in the high nibble, tens digit in the low nibble.
  function automatic logic [7:0] pair_byte(input logic [6:0] v);
    logic [3:0] tens;
    logic [6:0] units;
    tens = 4'd0;
    for (int i = 1; i <= 12; i++) begin
      if (v >= 7'(i * 10)) tens = 4'(i);
    end
    units = v - 7'(tens) * 7'd10;
    return {units[3:0], tens};
  endfunction

  // One restoring remainder step.
  function automatic logic [5:0] rem_step(input logic [5:0] r, input logic b,
                                          input logic [5:0] d);
    logic [6:0] t;
    t = {r, b};
    if (t >= {1'b0, d}) t = t - {1'b0, d};
    return t[5:0];
  endfunction

endpackage

`default_nettype wire

### src/clock_display_digit_formatter.sv
// Top level of the clock display formatter: three-stage digit pipeline.
//
// Input stream s_axis carries one time sample per beat; output stream
// m_axis carries the display word, time/date flag, colon code and seconds
// of the day for that sample. One result beat per input beat, in order.
// A beat accepted on s_axis passes the stage 1, 2 and 3 registers in turn;
// stage 3 drives m_axis. Throughput is one beat per cycle unless
// m_axis_tready stalls: stage 1 runs half of the minute remainder and the
// hour conversion, stage 2 the rest of the remainder, the window decision
// and the digit split, stage 3 the word assembly and colon code.
// Each stage holds its beat while the next one is full and stalled, so a
// deasserted m_axis_tready backs up into s_axis_tready only once all three
// stages hold data; nothing is dropped or repeated.
// Configuration is written through cfg_we/cfg_index/cfg_data while the
// pipeline is empty, a rule for the user that the block does not enforce;
// indexes past the last register are ignored. Reset (rst, synchronous) empties
// the pipeline and loads the register defaults: 24-hour, leading zero shown,
// day-month-year, no alternate window, no invert, time shown, colons off.
`default_nettype none

module clock_display_digit_formatter (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_we,
  input  wire logic [cdf_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [cdf_pkg::CFG_DAT_W-1:0]       cfg_data,
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  // hour[4:0], minute[10:5], second[16:11], day_of_month[21:17],
  // month_number[25:22], year_two_digit[32:26], zero pad
  input  wire logic [cdf_pkg::IN_BYTES*8-1:0]      s_axis_tdata,
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  // digit_word[31:0], showing_time[32], colon_pattern[35:33],
  // seconds_of_day[52:36], zero pad
  output logic [cdf_pkg::OUT_BYTES*8-1:0]          m_axis_tdata
);

  logic       twelve_hour_mode;
  logic       show_leading_zero;
  logic [1:0] date_order;
  logic [5:0] alternate_period_minutes;
  logic       alternate_invert;
  logic       time_mode;
  logic [2:0] indicator_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      twelve_hour_mode         <= cdf_pkg::RST_TWELVE_HOUR;
      show_leading_zero        <= cdf_pkg::RST_LEADING_ZERO;
      date_order               <= cdf_pkg::RST_DATE_ORDER;
      alternate_period_minutes <= cdf_pkg::RST_ALT_PERIOD;
      alternate_invert         <= cdf_pkg::RST_ALT_INVERT;
      time_mode                <= cdf_pkg::RST_TIME_MODE;
      indicator_mode           <= cdf_pkg::RST_INDICATOR;
    end else if (cfg_we) begin
      unique case (cfg_index)
        cdf_pkg::REG_TWELVE_HOUR:  twelve_hour_mode         <= cfg_data[0];
        cdf_pkg::REG_LEADING_ZERO: show_leading_zero        <= cfg_data[0];
        cdf_pkg::REG_DATE_ORDER:   date_order               <= cfg_data[1:0];
        cdf_pkg::REG_ALT_PERIOD:   alternate_period_minutes <= cfg_data[5:0];
        cdf_pkg::REG_ALT_INVERT:   alternate_invert         <= cfg_data[0];
        cdf_pkg::REG_TIME_MODE:    time_mode                <= cfg_data[0];
        cdf_pkg::REG_INDICATOR:    indicator_mode           <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  logic v1, v2, v3;
  logic adv1, adv2, adv3;

  assign adv3          = !v3 || m_axis_tready;
  assign adv2          = !v2 || adv3;
  assign adv1          = !v1 || adv2;
  assign s_axis_tready = adv1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (adv1) v1 <= s_axis_tvalid;
      if (adv2) v2 <= v1;
      if (adv3) v3 <= v2;
    end
  end

  // Stage 1
  logic [4:0] in_hour;
  logic [5:0] in_minute;
  cdf_pkg::s1_t s1_next, s1;

  assign in_hour   = s_axis_tdata[4:0];
  assign in_minute = s_axis_tdata[10:5];

  always_comb begin
    logic [5:0] r;
    r = 6'd0;
    for (int i = 5; i >= 3; i--) begin
      r = cdf_pkg::rem_step(r, in_minute[i], alternate_period_minutes);
    end
    s1_next.minute    = in_minute;
    s1_next.second    = s_axis_tdata[16:11];
    s1_next.day       = s_axis_tdata[21:17];
    s1_next.month     = s_axis_tdata[25:22];
    s1_next.year      = s_axis_tdata[32:26];
    s1_next.pm        = in_hour >= cdf_pkg::NOON;
    s1_next.hour_disp = in_hour;
    if (twelve_hour_mode) begin
      if (in_hour > cdf_pkg::NOON) s1_next.hour_disp = in_hour - cdf_pkg::NOON;
      else if (in_hour == 5'd0)    s1_next.hour_disp = cdf_pkg::NOON;
    end
    s1_next.rem      = r;
    s1_next.hour_sec = 17'(in_hour) * 17'd3600;
    s1_next.min_sec  = 12'(in_minute) * 12'd60 + 12'(s_axis_tdata[16:11]);
  end

  always_ff @(posedge clk) begin
    if (adv1 && s_axis_tvalid) s1 <= s1_next;
  end

  // Stage 2
  cdf_pkg::s2_t s2_next, s2;

  always_comb begin
    logic [5:0] r;
    logic       win;
    logic [7:0] hb;
    r = s1.rem;
    for (int i = 2; i >= 0; i--) begin
      r = cdf_pkg::rem_step(r, s1.minute[i], alternate_period_minutes);
    end
    win = (alternate_period_minutes != 6'd0) && (r == 6'd0) &&
          (s1.second >= cdf_pkg::WIN_FIRST) && (s1.second <= cdf_pkg::WIN_LAST);
    hb  = cdf_pkg::pair_byte(7'(s1.hour_disp));
    s2_next.show_time = time_mode ^ (win ^ alternate_invert);
    s2_next.odd       = s1.second[0];
    s2_next.pm        = s1.pm;
    s2_next.hour_byte = {hb[7:4],
                         (s1.hour_disp < 5'd10 && !show_leading_zero) ?
                         cdf_pkg::BLANK_NIBBLE : hb[3:0]};
    s2_next.min_byte   = cdf_pkg::pair_byte(7'(s1.minute));
    s2_next.sec_byte   = cdf_pkg::pair_byte(7'(s1.second));
    s2_next.day_byte   = cdf_pkg::pair_byte(7'(s1.day));
    s2_next.month_byte = cdf_pkg::pair_byte(7'(s1.month));
    s2_next.year_byte  = cdf_pkg::pair_byte(s1.year);
    s2_next.sod        = s1.hour_sec + 17'(s1.min_sec);
  end

  always_ff @(posedge clk) begin
    if (adv2 && v1) s2 <= s2_next;
  end

  // Stage 3
  logic [31:0] word_next;
  logic [2:0]  colon_next;
  logic [31:0] digit_word;
  logic        showing_time;
  logic [2:0]  colon_pattern;
  logic [16:0] seconds_of_day;

  always_comb begin
    if (s2.show_time) begin
      word_next = {cdf_pkg::TOP_BYTE, s2.sec_byte, s2.min_byte, s2.hour_byte};
    end else begin
      case (date_order)
        cdf_pkg::DATE_DMY:
          word_next = {cdf_pkg::TOP_BYTE, s2.year_byte, s2.month_byte, s2.day_byte};
        cdf_pkg::DATE_MDY:
          word_next = {cdf_pkg::TOP_BYTE, s2.year_byte, s2.day_byte, s2.month_byte};
        default:
          word_next = {cdf_pkg::TOP_BYTE, s2.day_byte, s2.month_byte, s2.year_byte};
      endcase
    end
    colon_next = cdf_pkg::COLON_OFF;
    if (s2.show_time) begin
      unique case (indicator_mode)
        cdf_pkg::IND_ALWAYS: colon_next = cdf_pkg::COLON_ON;
        cdf_pkg::IND_BLINK:  colon_next = s2.odd ? cdf_pkg::COLON_ON : cdf_pkg::COLON_OFF;
        cdf_pkg::IND_PM:     colon_next = s2.pm ? cdf_pkg::COLON_ON : cdf_pkg::COLON_OFF;
        cdf_pkg::IND_ALT_A:  colon_next = s2.odd ? cdf_pkg::COLON_C2 : cdf_pkg::COLON_C3;
        cdf_pkg::IND_ALT_B:  colon_next = s2.odd ? cdf_pkg::COLON_C4 : cdf_pkg::COLON_C5;
        default:             colon_next = cdf_pkg::COLON_OFF;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (adv3 && v2) begin
      digit_word     <= word_next;
      showing_time   <= s2.show_time;
      colon_pattern  <= colon_next;
      seconds_of_day <= s2.sod;
    end
  end

  assign m_axis_tvalid = v3;
  assign m_axis_tdata  = {3'd0, seconds_of_day, colon_pattern, showing_time, digit_word};

endmodule

`default_nettype wire

### src/cdf_checker.sv
// Port-level checker for the clock display formatter, bound to the top level.
`default_nettype none

`include "clock_display_digit_formatter_macros.svh"

module cdf_checker (
  input wire logic                               clk,
  input wire logic                               rst,
  input wire logic                               m_axis_tvalid,
  input wire logic                               m_axis_tready,
  input wire logic [cdf_pkg::OUT_BYTES*8-1:0]    m_axis_tdata
);

  `CDF_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
  `CDF_ASSERT_SAME(a_top_byte, m_axis_tvalid, m_axis_tdata[31:24] == cdf_pkg::TOP_BYTE)
  `CDF_ASSERT_SAME(a_date_no_colon, m_axis_tvalid && !m_axis_tdata[32],
                   m_axis_tdata[35:33] == cdf_pkg::COLON_OFF)
  `CDF_ASSERT_SAME(a_empty_after_reset, $past(rst), !m_axis_tvalid)

endmodule

bind clock_display_digit_formatter cdf_checker u_cdf_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

### test/clock_display_digit_formatter_test.sv
// Testbench for the clock display digit formatter: directed and random samples.
`timescale 1ns / 1ps

module clock_display_digit_formatter_test;

  localparam logic [2:0] IND_OFF     = 3'd0;
  localparam logic [1:0] DATE_YMD    = 2'd2;
  localparam logic [1:0] DATE_SPARE  = 2'd3;
  localparam int PHASES              = 12;
  localparam int ITEMS_PER_PHASE     = 84;
  localparam int HOLD_CYCLES         = 300;
  localparam int CYCLE_LIMIT         = 200000;

  typedef struct packed {
    logic [6:0] year;
    logic [3:0] month;
    logic [4:0] day;
    logic [5:0] second;
    logic [5:0] minute;
    logic [4:0] hour;
  } sample_t;

  typedef struct packed {
    logic [16:0] seconds_of_day;
    logic [2:0]  colon;
    logic        show_time;
    logic [31:0] word;
  } display_t;

  typedef struct {
    logic       twelve_hour;
    logic       leading_zero;
    logic [1:0] date_order;
    logic [5:0] alt_period;
    logic       alt_invert;
    logic       time_mode;
    logic [2:0] indicator;
  } display_settings_t;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            cfg_we = 1'b0;
  logic [cdf_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
  logic [cdf_pkg::CFG_DAT_W-1:0]   cfg_data = '0;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [cdf_pkg::IN_BYTES*8-1:0]  s_axis_tdata = '0;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [cdf_pkg::OUT_BYTES*8-1:0] m_axis_tdata;

  display_settings_t settings = '{1'b0, 1'b1, 2'd0, 6'd0, 1'b0, 1'b1, 3'd0};
  sample_t  samples_to_send[$];
  display_t displays_due[$];
  sample_t  offered;
  int issued_count = 0;
  int checked_count = 0;
  int mismatches = 0;
  int time_beats = 0;
  int date_beats = 0;
  int cycles = 0;
  int burst_left = 0;
  int gap_left = 0;
  int hold_left = 0;
  int pattern_age = 0;
  logic [31:0] stall_pattern = '1;
  logic send_bursty = 1'b1;
  logic recv_patterned = 1'b1;
  logic hold_request = 1'b0;
  logic hold_taken = 1'b0;

  clock_display_digit_formatter DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #4 clk = ~clk;

  function automatic logic [7:0] digit_pair(input int v);
    return {4'(v % 10), 4'(v / 10)};
  endfunction

  function automatic display_t format_sample(input sample_t s);
    display_t r;
    logic in_window;
    logic odd;
    int h;
    logic [3:0] hour_tens;
    logic [7:0] d, m, y;
    r = '0;
    in_window = 1'b0;
    if (settings.alt_period != 0 && (s.minute % settings.alt_period) == 0)
      in_window = (s.second >= cdf_pkg::WIN_FIRST && s.second <= cdf_pkg::WIN_LAST);
    if (settings.alt_invert) in_window = !in_window;
    r.show_time = settings.time_mode ^ in_window;
    odd = s.second[0];
    r.seconds_of_day = 17'(s.hour * 3600 + s.minute * 60 + s.second);
    if (r.show_time) begin
      h = s.hour;
      if (settings.twelve_hour) begin
        if (h > cdf_pkg::NOON) h = h - cdf_pkg::NOON;
        else if (h == 0) h = cdf_pkg::NOON;
      end
      hour_tens = (h < 10 && !settings.leading_zero) ? cdf_pkg::BLANK_NIBBLE : 4'(h / 10);
      r.word = {cdf_pkg::TOP_BYTE, digit_pair(s.second), digit_pair(s.minute),
                4'(h % 10), hour_tens};
      case (settings.indicator)
        cdf_pkg::IND_ALWAYS: r.colon = cdf_pkg::COLON_ON;
        cdf_pkg::IND_BLINK:  r.colon = odd ? cdf_pkg::COLON_ON : cdf_pkg::COLON_OFF;
        cdf_pkg::IND_PM:
          r.colon = (s.hour >= cdf_pkg::NOON) ? cdf_pkg::COLON_ON : cdf_pkg::COLON_OFF;
        cdf_pkg::IND_ALT_A:  r.colon = odd ? cdf_pkg::COLON_C2 : cdf_pkg::COLON_C3;
        cdf_pkg::IND_ALT_B:  r.colon = odd ? cdf_pkg::COLON_C4 : cdf_pkg::COLON_C5;
        default:             r.colon = cdf_pkg::COLON_OFF;
      endcase
    end else begin
      d = digit_pair(s.day);
      m = digit_pair(s.month);
      y = digit_pair(s.year);
      r.colon = cdf_pkg::COLON_OFF;
      case (settings.date_order)
        cdf_pkg::DATE_DMY: r.word = {cdf_pkg::TOP_BYTE, y, m, d};
        cdf_pkg::DATE_MDY: r.word = {cdf_pkg::TOP_BYTE, y, d, m};
        default:           r.word = {cdf_pkg::TOP_BYTE, d, m, y};
      endcase
    end
    return r;
  endfunction

  function automatic sample_t random_sample(input logic [5:0] period);
    sample_t s;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      s = 33'({$urandom, $urandom});
    end else begin
      s.hour   = 5'($urandom_range(0, 23));
      s.minute = 6'($urandom_range(0, 59));
      s.second = 6'($urandom_range(0, 59));
      s.day    = 5'($urandom_range(1, 31));
      s.month  = 4'($urandom_range(1, 12));
      s.year   = 7'($urandom_range(0, 99));
      // aim at the alternate window edges
      if (pick < 40 && period != 0) begin
        s.minute = 6'(period * $urandom_range(0, 63 / period));
        s.second = 6'($urandom_range(43, 54));
      end
    end
    return s;
  endfunction

  task automatic send_sample(input int h, input int mi, input int s, input int d,
                             input int mo, input int y);
    sample_t t;
    t.hour = 5'(h);
    t.minute = 6'(mi);
    t.second = 6'(s);
    t.day = 5'(d);
    t.month = 4'(mo);
    t.year = 7'(y);
    samples_to_send.push_back(t);
    issued_count++;
  endtask

  task automatic settle();
    while (checked_count < issued_count) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_setting(input logic [cdf_pkg::CFG_IDX_W-1:0] idx,
                               input logic [cdf_pkg::CFG_DAT_W-1:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    case (idx)
      cdf_pkg::REG_TWELVE_HOUR:  settings.twelve_hour = value[0];
      cdf_pkg::REG_LEADING_ZERO: settings.leading_zero = value[0];
      cdf_pkg::REG_DATE_ORDER:   settings.date_order = value[1:0];
      cdf_pkg::REG_ALT_PERIOD:   settings.alt_period = value[5:0];
      cdf_pkg::REG_ALT_INVERT:   settings.alt_invert = value[0];
      cdf_pkg::REG_TIME_MODE:    settings.time_mode = value[0];
      cdf_pkg::REG_INDICATOR:    settings.indicator = value[2:0];
      default: ;
    endcase
  endtask

  task automatic end_writes();
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Sender: bursts of beats with random gaps, or a steady stream when send_bursty is clear.
  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) displays_due.push_back(format_sample(offered));
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0) begin
          gap_left = gap_left - 1;
          s_axis_tvalid <= 1'b0;
        end else if (samples_to_send.size() > 0) begin
          offered = samples_to_send.pop_front();
          s_axis_tdata <= {7'd0, offered};
          s_axis_tvalid <= 1'b1;
          if (send_bursty) begin
            burst_left = burst_left - 1;
            if (burst_left <= 0) begin
              burst_left = $urandom_range(1, 16);
              gap_left = $urandom_range(1, 6);
            end
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: check each beat, stall on a rotating pattern (when recv_patterned is set), hold off once.
  always @(posedge clk) begin
    display_t got;
    display_t want;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = display_t'(m_axis_tdata[$bits(display_t)-1:0]);
        checked_count++;
        if (displays_due.size() == 0) begin
          $error("result beat with no expectation: digit_word %h", got.word);
          mismatches++;
        end else begin
          want = displays_due.pop_front();
          if (want.show_time) time_beats++;
          else date_beats++;
          if (got.word !== want.word) begin
            $error("digit_word: expected %h, actual %h", want.word, got.word);
            mismatches++;
          end
          if (got.show_time !== want.show_time) begin
            $error("showing_time: expected %0d, actual %0d", want.show_time, got.show_time);
            mismatches++;
          end
          if (got.colon !== want.colon) begin
            $error("colon_pattern: expected %0d, actual %0d", want.colon, got.colon);
            mismatches++;
          end
          if (got.seconds_of_day !== want.seconds_of_day) begin
            $error("seconds_of_day: expected %0d, actual %0d",
                   want.seconds_of_day, got.seconds_of_day);
            mismatches++;
          end
        end
      end
      if (hold_request && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        m_axis_tready <= 1'b0;
      end else if (recv_patterned) begin
        if (pattern_age == 0) begin
          stall_pattern = $urandom | $urandom;
          pattern_age = $urandom_range(16, 96);
        end
        m_axis_tready <= stall_pattern[0];
        stall_pattern = {stall_pattern[0], stall_pattern[31:1]};
        pattern_age = pattern_age - 1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d of %0d beats checked",
               cycles, checked_count, issued_count);
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    display_settings_t next;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset defaults: 24-hour time, leading zero shown
    send_sample(0, 0, 0, 1, 1, 0);
    send_sample(23, 59, 59, 31, 12, 99);
    send_sample(31, 63, 63, 31, 15, 127);
    send_sample(12, 30, 45, 15, 6, 50);
    send_sample(9, 5, 1, 2, 3, 4);
    settle();

    write_setting(cdf_pkg::REG_TWELVE_HOUR, 6'd1);
    write_setting(cdf_pkg::REG_LEADING_ZERO, 6'd0);
    write_setting(cdf_pkg::REG_INDICATOR, 6'(cdf_pkg::IND_PM));
    end_writes();
    send_sample(0, 1, 2, 1, 1, 1);
    send_sample(9, 9, 9, 1, 1, 1);
    send_sample(12, 0, 0, 1, 1, 1);
    send_sample(13, 0, 0, 1, 1, 1);
    send_sample(23, 0, 0, 1, 1, 1);
    send_sample(31, 0, 0, 1, 1, 1);
    settle();

    write_setting(cdf_pkg::REG_TIME_MODE, 6'd0);
    write_setting(cdf_pkg::REG_DATE_ORDER, 6'(DATE_YMD));
    end_writes();
    send_sample(0, 0, 0, 1, 1, 0);
    send_sample(23, 59, 59, 31, 12, 99);
    send_sample(31, 63, 63, 31, 15, 127);
    settle();

    write_setting(cdf_pkg::REG_DATE_ORDER, 6'(DATE_SPARE));
    end_writes();
    send_sample(10, 20, 30, 17, 8, 42);
    settle();

    // window opens on seconds 45..52 of minutes that are multiples of five
    write_setting(cdf_pkg::REG_TIME_MODE, 6'd1);
    write_setting(cdf_pkg::REG_ALT_PERIOD, 6'd5);
    end_writes();
    send_sample(8, 0, 44, 5, 5, 25);
    send_sample(8, 0, 45, 5, 5, 25);
    send_sample(8, 10, 52, 5, 5, 25);
    send_sample(8, 10, 53, 5, 5, 25);
    send_sample(8, 7, 47, 5, 5, 25);
    settle();

    for (int p = 1; p <= PHASES; p++) begin
      if (p == 1) begin
        next = '{1'b0, 1'b0, cdf_pkg::DATE_DMY, 6'd0, 1'b0, 1'b0, IND_OFF};
      end else if (p == 2) begin
        next = '{1'b1, 1'b1, DATE_SPARE, 6'd63, 1'b1, 1'b1, 3'(p * 0 - 1)};
      end else begin
        next.twelve_hour = 1'($urandom_range(0, 1));
        next.leading_zero = 1'($urandom_range(0, 1));
        next.date_order = 2'(p % 4);
        next.alt_period = (p % 3 == 0) ? 6'($urandom_range(0, 63)) : 6'($urandom_range(1, 4));
        next.alt_invert = 1'($urandom_range(0, 1));
        next.time_mode = (p == 7 || p == 10) ? 1'b0 : 1'b1;
        next.indicator = 3'(p % 8);
      end
      write_setting(cdf_pkg::REG_TWELVE_HOUR, 6'(next.twelve_hour));
      write_setting(cdf_pkg::REG_LEADING_ZERO, 6'(next.leading_zero));
      write_setting(cdf_pkg::REG_DATE_ORDER, 6'(next.date_order));
      write_setting(cdf_pkg::REG_ALT_PERIOD, 6'(next.alt_period));
      write_setting(cdf_pkg::REG_ALT_INVERT, 6'(next.alt_invert));
      write_setting(cdf_pkg::REG_TIME_MODE, 6'(next.time_mode));
      write_setting(cdf_pkg::REG_INDICATOR, 6'(next.indicator));
      end_writes();

      send_bursty = (p % 3 != 0) && (p != 4);
      recv_patterned = (p % 4 != 1);
      // hold the output long enough to back up into the input
      if (p == 4) hold_request = 1'b1;
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        samples_to_send.push_back(random_sample(settings.alt_period));
        issued_count++;
      end
      settle();
    end

    repeat (8) @(posedge clk);
    if (displays_due.size() != 0) begin
      $error("%0d expected results never arrived", displays_due.size());
      mismatches++;
    end
    $display("Checked %0d beats (%0d time, %0d date) over %0d register settings,",
             checked_count, time_beats, date_beats, PHASES + 5);
    $display("with sender gaps, receiver stalls and one %0d-cycle output hold-off.",
             HOLD_CYCLES);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
